@@ rtl/core/rabs_pkg.sv @@
// ----------------------------------------------------------------------------
// rabs_pkg: shared types and constants for the rank-by-sort block
// Widths of the value store, fill counter, rank and the unit control group.
// ----------------------------------------------------------------------------
package rabs_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int STORE_DEPTH  = 64;
  localparam int VALUE_W      = 32;
  localparam int RANK_W       = 6;
  localparam int ADDR_W       = 6;
  localparam int FILL_W       = 7;

  localparam logic [FILL_W-1:0] CAPACITY = FILL_W'(MAX_ELEMENTS);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [RANK_W-1:0]         rank_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [FILL_W-1:0]         fill_t;

  // control from the sequencer to the shared compare unit
  typedef struct packed {
    logic load_key;
    logic accumulate;
  } unit_ctl_t;

endpackage

@@ rtl/core/rabs_channels.sv @@
// ----------------------------------------------------------------------------
// rabs_channels: valid/ready channels of the rank-by-sort block
// Input request channel (value, is_last) and result channel (rank, flags).
// ----------------------------------------------------------------------------
interface rabs_item_if;
  logic             valid;
  logic             ready;
  rabs_pkg::value_t value;
  logic             is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface rabs_rank_if;
  logic            valid;
  logic            ready;
  rabs_pkg::rank_t rank;
  logic            last_rank;
  logic            overflowed;

  modport source (output valid, output rank, output last_rank, output overflowed,
                  input ready);
  modport sink   (input valid, input rank, input last_rank, input overflowed,
                  output ready);
endinterface

@@ rtl/core/rabs_ram.sv @@
// ----------------------------------------------------------------------------
// rabs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rabs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/rabs_rank_unit.sv @@
// ----------------------------------------------------------------------------
// rabs_rank_unit: shared signed comparator and rank accumulator
// Holds the key of the element being ranked and counts smaller values.
// ----------------------------------------------------------------------------
module rabs_rank_unit (
  input  logic                clk,
  input  rabs_pkg::unit_ctl_t ctl,
  input  rabs_pkg::value_t    rdata,
  output rabs_pkg::rank_t     count
);

  rabs_pkg::value_t key;

  always_ff @(posedge clk) begin
    if (ctl.load_key) begin
      key   <= rdata;
      count <= '0;
    end else if (ctl.accumulate && (rdata < key)) begin
      count <= count + rabs_pkg::RANK_W'(1);
    end
  end

endmodule

@@ rtl/core/rabs_ctrl.sv @@
// ----------------------------------------------------------------------------
// rabs_ctrl: load and ranking sequencer
// Fills the value store, then walks it once per element and emits ranks.
// ----------------------------------------------------------------------------
module rabs_ctrl (
  input  logic                clk,
  input  logic                rst,
  rabs_item_if.sink           items,
  rabs_rank_if.source         ranks,
  output logic                ram_we,
  output rabs_pkg::addr_t     ram_waddr,
  output rabs_pkg::value_t    ram_wdata,
  output rabs_pkg::addr_t     ram_raddr,
  output rabs_pkg::unit_ctl_t unit_ctl,
  input  rabs_pkg::rank_t     count
);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_READ_I = 3'd1;
  localparam logic [2:0] ST_KEY    = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]      state;
  rabs_pkg::fill_t fill;
  logic            ovf;
  rabs_pkg::addr_t idx_i;
  rabs_pkg::addr_t idx_c;
  logic            out_valid;

  logic            in_take;
  logic            room;
  rabs_pkg::fill_t fill_last;
  logic            scan_end;
  logic            item_end;
  logic            emit_ok;

  assign items.ready = (state == ST_LOAD);
  assign in_take     = items.valid && items.ready;
  assign room        = fill < rabs_pkg::CAPACITY;
  assign fill_last   = fill - rabs_pkg::FILL_W'(1);
  assign scan_end    = {1'b0, idx_c} == fill_last;
  assign item_end    = {1'b0, idx_i} == fill_last;
  assign emit_ok     = !out_valid || ranks.ready;

  assign ram_we    = in_take && room;
  assign ram_waddr = fill[rabs_pkg::ADDR_W-1:0];
  assign ram_wdata = items.value;

  assign unit_ctl.load_key   = (state == ST_KEY);
  assign unit_ctl.accumulate = (state == ST_SCAN);

  assign ranks.valid = out_valid;

  // read address: own element first, then a sweep one ahead of the compare
  always_comb begin
    unique case (state)
      ST_READ_I: ram_raddr = idx_i;
      ST_KEY:    ram_raddr = '0;
      ST_SCAN:   ram_raddr = idx_c + rabs_pkg::ADDR_W'(1);
      default:   ram_raddr = idx_i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      fill      <= '0;
      ovf       <= 1'b0;
      idx_i     <= '0;
      idx_c     <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_take) begin
            if (room) begin
              fill <= fill + rabs_pkg::FILL_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (items.is_last) begin
              idx_i <= '0;
              state <= ST_READ_I;
            end
          end
        end
        ST_READ_I: begin
          state <= ST_KEY;
        end
        ST_KEY: begin
          idx_c <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_end) begin
            state <= ST_EMIT;
          end else begin
            idx_c <= idx_c + rabs_pkg::ADDR_W'(1);
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            if (item_end) begin
              fill  <= '0;
              ovf   <= 1'b0;
              state <= ST_LOAD;
            end else begin
              idx_i <= idx_i + rabs_pkg::ADDR_W'(1);
              state <= ST_READ_I;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // result valid: set on emit, cleared once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && emit_ok) begin
      out_valid <= 1'b1;
    end else if (ranks.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && emit_ok) begin
      ranks.rank       <= count;
      ranks.last_rank  <= item_end;
      ranks.overflowed <= ovf;
    end
  end

endmodule

@@ rtl/core/rank_assign_by_sort.sv @@
// ----------------------------------------------------------------------------
// rank_assign_by_sort: rank of each element of a loaded sequence
// Stores signed values, then emits for each one the count of smaller values.
// ----------------------------------------------------------------------------
// usage
//   items: one request per signed 32-bit value, is_last on the final one.
//     Up to MAX_ELEMENTS values are kept; the rest are dropped and the
//     overflowed flag is raised on every rank of that sequence.
//   ranks: one result per stored value, in load order, last_rank on the final
//     one; rank = number of stored values strictly smaller, so equal values
//     share the lowest rank.
// timing
//   loading takes one cycle per request, items.ready high between sequences.
//   after is_last, each rank reads and latches the element's own key, then
//   sweeps all n stored values through the single read port, compared by the
//   one shared comparator, and is then emitted. items.ready is low meanwhile.
//   a stalled ranks channel holds the ranking sequencer in its emit step;
//   the final rank may still wait while the next sequence is loading.
// reset
//   rst (synchronous) empties the store count, clears the overflow flag and
//   drops any pending result; stored values need no clearing.
// ----------------------------------------------------------------------------
module rank_assign_by_sort (
  input  logic        clk,
  input  logic        rst,
  rabs_item_if.sink   items,
  rabs_rank_if.source ranks
);

  // value store write side (load) and read side (ranking sweep)
  logic                ram_we;
  rabs_pkg::addr_t     ram_waddr;
  rabs_pkg::value_t    ram_wdata;
  rabs_pkg::addr_t     ram_raddr;
  rabs_pkg::value_t    ram_rdata;

  // sequencer to compare unit
  rabs_pkg::unit_ctl_t unit_ctl;
  rabs_pkg::rank_t     count;

  // element store, registered read
  rabs_ram #(
    .WIDTH (rabs_pkg::VALUE_W),
    .DEPTH (rabs_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // one signed comparator reused for every pair
  rabs_rank_unit u_unit (
    .clk   (clk),
    .ctl   (unit_ctl),
    .rdata (ram_rdata),
    .count (count)
  );

  // load / rank / emit sequencer with the output register
  rabs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .ranks     (ranks),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .unit_ctl  (unit_ctl),
    .count     (count)
  );

endmodule
